@@ design/stack_vm_compare_and_branch_unit_assert.svh @@
// Assertion macros for the compare and branch unit.
`ifndef STACK_VM_COMPARE_AND_BRANCH_UNIT_ASSERT_SVH
`define STACK_VM_COMPARE_AND_BRANCH_UNIT_ASSERT_SVH
// Implication checked every clock edge outside reset.
`define SVCB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SVCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ design/svcb_pkg.sv @@
// Package with operation codes and result types of the compare and branch unit.
package svcb_pkg;
  localparam logic [4:0] OP_LCMP    = 5'd0;
  localparam logic [4:0] OP_FCMPL   = 5'd1;
  localparam logic [4:0] OP_FCMPG   = 5'd2;
  localparam logic [4:0] OP_DCMPL   = 5'd3;
  localparam logic [4:0] OP_DCMPG   = 5'd4;
  localparam logic [4:0] OP_IFEQ    = 5'd5;
  localparam logic [4:0] OP_IFNE    = 5'd6;
  localparam logic [4:0] OP_IFLT    = 5'd7;
  localparam logic [4:0] OP_IFGE    = 5'd8;
  localparam logic [4:0] OP_IFGT    = 5'd9;
  localparam logic [4:0] OP_IFLE    = 5'd10;
  localparam logic [4:0] OP_ICMPEQ  = 5'd11;
  localparam logic [4:0] OP_ICMPNE  = 5'd12;
  localparam logic [4:0] OP_ICMPLT  = 5'd13;
  localparam logic [4:0] OP_ICMPGE  = 5'd14;
  localparam logic [4:0] OP_ICMPGT  = 5'd15;
  localparam logic [4:0] OP_ICMPLE  = 5'd16;
  localparam logic [4:0] OP_ACMPEQ  = 5'd17;
  localparam logic [4:0] OP_ACMPNE  = 5'd18;

  localparam logic signed [1:0] CMP_LT = -2'sd1;
  localparam logic signed [1:0] CMP_EQ = 2'sd0;
  localparam logic signed [1:0] CMP_GT = 2'sd1;

  typedef struct packed {
    logic [4:0]  operation;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic signed [15:0] branch_offset;
    logic [31:0] current_pc;
  } item_t;

  typedef struct packed {
    logic signed [1:0] compare_result;
    logic        is_branch;
    logic        branch_taken;
    logic [31:0] next_target;
  } result_t;

  function automatic logic signed [1:0] ieee_cmp(input logic [63:0] a, input logic [63:0] b,
                                                 input logic dbl, input logic nan_gt);
    logic sa, sb, nan_a, nan_b;
    logic [62:0] ma, mb;
    begin
      if (dbl) begin
        sa = a[63]; sb = b[63];
        ma = a[62:0]; mb = b[62:0];
        nan_a = (&a[62:52]) && (|a[51:0]);
        nan_b = (&b[62:52]) && (|b[51:0]);
      end else begin
        sa = a[31]; sb = b[31];
        ma = {32'd0, a[30:0]}; mb = {32'd0, b[30:0]};
        nan_a = (&a[30:23]) && (|a[22:0]);
        nan_b = (&b[30:23]) && (|b[22:0]);
      end
      if (nan_a || nan_b) ieee_cmp = nan_gt ? CMP_GT : CMP_LT;
      else if (ma == 63'd0 && mb == 63'd0) ieee_cmp = CMP_EQ;
      else if (sa != sb) ieee_cmp = sa ? CMP_LT : CMP_GT;
      else if (ma == mb) ieee_cmp = CMP_EQ;
      else if ((ma > mb) != sa) ieee_cmp = CMP_GT;
      else ieee_cmp = CMP_LT;
    end
  endfunction
endpackage

@@ design/svcb_exec.sv @@
// Combinational compare and branch evaluation of one item.
module svcb_exec #(
  parameter int PC_WIDTH = 32
) (
  input  svcb_pkg::item_t   item,
  output svcb_pkg::result_t res
);
  import svcb_pkg::*;
  logic signed [31:0] ia, ib;
  logic signed [63:0] la, lb;
  logic eq, lt, gt;
  logic [PC_WIDTH-1:0] tgt;
  logic [63:0] tgt_w;

  assign la = item.operand_a;
  assign lb = item.operand_b;
  assign ia = item.operand_a[31:0];
  assign ib = (item.operation <= OP_IFLE) ? 32'sd0 : item.operand_b[31:0];
  assign eq = ia == ib;
  assign lt = ia < ib;
  assign gt = ia > ib;
  assign tgt = PC_WIDTH'(item.current_pc) + PC_WIDTH'(item.branch_offset);
  assign tgt_w = 64'(tgt);

  always_comb begin
    res = '0;
    unique case (item.operation)
      OP_LCMP:  res.compare_result = (la > lb) ? CMP_GT : ((la == lb) ? CMP_EQ : CMP_LT);
      OP_FCMPL: res.compare_result = ieee_cmp(item.operand_a, item.operand_b, 1'b0, 1'b0);
      OP_FCMPG: res.compare_result = ieee_cmp(item.operand_a, item.operand_b, 1'b0, 1'b1);
      OP_DCMPL: res.compare_result = ieee_cmp(item.operand_a, item.operand_b, 1'b1, 1'b0);
      OP_DCMPG: res.compare_result = ieee_cmp(item.operand_a, item.operand_b, 1'b1, 1'b1);
      OP_IFEQ, OP_ICMPEQ: begin res.is_branch = 1'b1; res.branch_taken = eq; end
      OP_IFNE, OP_ICMPNE: begin res.is_branch = 1'b1; res.branch_taken = !eq; end
      OP_IFLT, OP_ICMPLT: begin res.is_branch = 1'b1; res.branch_taken = lt; end
      OP_IFGE, OP_ICMPGE: begin res.is_branch = 1'b1; res.branch_taken = !lt; end
      OP_IFGT, OP_ICMPGT: begin res.is_branch = 1'b1; res.branch_taken = gt; end
      OP_IFLE, OP_ICMPLE: begin res.is_branch = 1'b1; res.branch_taken = !gt; end
      OP_ACMPEQ: begin
        res.is_branch = 1'b1;
        res.branch_taken = item.operand_a == item.operand_b;
      end
      OP_ACMPNE: begin
        res.is_branch = 1'b1;
        res.branch_taken = item.operand_a != item.operand_b;
      end
      default: res = '0;
    endcase
    if (res.branch_taken) res.next_target = tgt_w[31:0];
  end
endmodule

@@ design/stack_vm_compare_and_branch_unit.sv @@
// Top level of the stack machine compare and branch unit.
// Executes one compare or conditional branch per item: an input register feeds short compare
// logic and a result register, so one item is accepted every cycle unless m_tready stalls the
// output; the rate is set by the single input and result stage pair, and the ready of the input
// side follows only whether the stages can advance.
module stack_vm_compare_and_branch_unit #(
  parameter int PC_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operation[4:0], operand_a[68:5], operand_b[132:69], branch_offset[148:133],
  // current_pc[180:149], zero fill
  input  logic [183:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // compare_result[1:0], is_branch[2], branch_taken[3], next_target[35:4], zero fill
  output logic [39:0]  m_tdata
);
  import svcb_pkg::*;
  `include "stack_vm_compare_and_branch_unit_assert.svh"

  item_t   in_item;
  logic    in_valid;
  result_t res_comb, out_res;
  logic    out_valid;
  logic    out_adv, in_adv;

  assign out_adv  = !out_valid || m_tready;
  assign in_adv   = !in_valid || out_adv;
  assign s_tready = in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_adv) in_valid <= s_tvalid;
      if (out_adv) out_valid <= in_valid;
    end
    if (in_adv && s_tvalid) begin
      in_item.operation     <= s_tdata[4:0];
      in_item.operand_a     <= s_tdata[68:5];
      in_item.operand_b     <= s_tdata[132:69];
      in_item.branch_offset <= s_tdata[148:133];
      in_item.current_pc    <= s_tdata[180:149];
    end
    if (out_adv && in_valid) out_res <= res_comb;
  end

  svcb_exec #(.PC_WIDTH(PC_WIDTH)) u_exec (.item(in_item), .res(res_comb));

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_res.next_target, out_res.branch_taken, out_res.is_branch,
                     out_res.compare_result};

  `SVCB_ASSERT_IMPL(a_cmp_no_branch, out_valid && out_res.compare_result != CMP_EQ,
    !out_res.is_branch, "compare result on a branch")
  `SVCB_ASSERT_IMPL(a_taken_is_branch, out_valid && out_res.branch_taken,
    out_res.is_branch, "taken without branch")
  `SVCB_ASSERT_IMPL(a_cmp_range, out_valid, out_res.compare_result != 2'b10,
    "compare result out of range")
  `SVCB_ASSERT_NEXT(a_stall_hold, out_valid && !m_tready, out_valid && $stable(out_res),
    "result changed while stalled")
endmodule

@@ sim/tb_stack_vm_compare_and_branch_unit.sv @@
// Testbench for the stack machine compare and branch unit: directed table plus random items.
`timescale 1ns / 100ps

module tb_stack_vm_compare_and_branch_unit;
  import svcb_pkg::*;

  localparam int LIMIT = 400000;

  typedef struct {
    logic [4:0]  op;
    logic [63:0] a;
    logic [63:0] b;
    logic [15:0] off;
    logic [31:0] pc;
    logic        known;
    logic [35:0] res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [183:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;

  logic [35:0] pending_results[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  stack_vm_compare_and_branch_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  function automatic int order_int(logic [63:0] a, logic [63:0] b, int bits);
    logic [63:0] ka, kb, sb;
    begin
      sb = 64'd1 << (bits - 1);
      ka = a ^ sb;
      kb = b ^ sb;
      if (bits == 32) begin
        ka = ka & 64'hFFFF_FFFF;
        kb = kb & 64'hFFFF_FFFF;
      end
      return (ka > kb) ? 1 : (ka == kb) ? 0 : -1;
    end
  endfunction

  function automatic int order_float(logic [63:0] a, logic [63:0] b, bit dbl, int nan_res);
    logic [63:0] ma, mb;
    logic na, nb, nan;
    begin
      if (dbl) begin
        ma = {1'b0, a[62:0]}; mb = {1'b0, b[62:0]};
        na = a[63]; nb = b[63];
        nan = (a[62:52] == 11'h7FF && a[51:0] != 0) || (b[62:52] == 11'h7FF && b[51:0] != 0);
      end else begin
        ma = {33'd0, a[30:0]}; mb = {33'd0, b[30:0]};
        na = a[31]; nb = b[31];
        nan = (a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0);
      end
      if (nan) return nan_res;
      if (ma == 0 && mb == 0) return 0;
      if (na != nb) return na ? -1 : 1;
      if (ma == mb) return 0;
      if (!na) return (ma > mb) ? 1 : -1;
      return (ma > mb) ? -1 : 1;
    end
  endfunction

  function automatic logic [35:0] branch_outcome(logic [4:0] op, logic [63:0] a, logic [63:0] b,
                                                 logic [15:0] off, logic [31:0] pc);
    int r;
    int k;
    logic [1:0] cmp;
    logic br, taken;
    logic [31:0] target;
    begin
      r = 0; cmp = 2'b00; br = 1'b0; taken = 1'b0; target = '0;
      case (op)
        OP_LCMP: r = order_int(a, b, 64);
        OP_FCMPL, OP_FCMPG: r = order_float(a, b, 1'b0, (op == OP_FCMPL) ? -1 : 1);
        OP_DCMPL, OP_DCMPG: r = order_float(a, b, 1'b1, (op == OP_DCMPL) ? -1 : 1);
        default: ;
      endcase
      if (op <= OP_DCMPG) cmp = r[1:0];
      if (op >= OP_IFEQ && op <= OP_ICMPLE) begin
        br = 1'b1;
        r = order_int({32'd0, a[31:0]}, (op <= OP_IFLE) ? 64'd0 : {32'd0, b[31:0]}, 32);
        k = (op <= OP_IFLE) ? op - OP_IFEQ : op - OP_ICMPEQ;
        case (k)
          0: taken = (r == 0);
          1: taken = (r != 0);
          2: taken = (r < 0);
          3: taken = (r >= 0);
          4: taken = (r > 0);
          default: taken = (r <= 0);
        endcase
      end else if (op == OP_ACMPEQ || op == OP_ACMPNE) begin
        br = 1'b1;
        taken = (op == OP_ACMPEQ) ? (a == b) : (a != b);
      end
      if (taken) target = pc + {{16{off[15]}}, off};
      return {target, taken, br, cmp};
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic send_instruction(logic [4:0] op, logic [63:0] a, logic [63:0] b,
                                  logic [15:0] off, logic [31:0] pc);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'd0, pc, off, b, a, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(branch_outcome(op, a, b, off, pc));
  endtask

  function automatic logic [63:0] pick_operand(bit dbl);
    logic [63:0] v;
    begin
      v = {$urandom, $urandom};
      case ($urandom_range(9))
        0: v = 64'd0;
        1: v = 64'h8000_0000_0000_0000;
        2: v = dbl ? 64'h7FF8_0000_0000_0001 : {32'd0, 32'h7FC0_0001};
        3: v = dbl ? 64'h7FF0_0000_0000_0000 : {32'd0, 32'h7F80_0000};
        4: v = {32'd0, $urandom_range(3)};
        5: v = {$urandom, 32'hFFFF_FFFF};
        default: ;
      endcase
      return v;
    end
  endfunction

  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    logic [35:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", {24'd0, m_tdata}, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[1:0] != want[1:0]) report_mismatch("compare_result", m_tdata[1:0], want[1:0]);
        if (m_tdata[2] != want[2]) report_mismatch("is_branch", m_tdata[2], want[2]);
        if (m_tdata[3] != want[3]) report_mismatch("branch_taken", m_tdata[3], want[3]);
        if (m_tdata[35:4] != want[35:4])
          report_mismatch("next_target", m_tdata[35:4], want[35:4]);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL stack_vm_compare_and_branch_unit");
      $finish;
    end
  end

  row_t directed[] = '{
    '{OP_LCMP, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 16'd4, 32'd100, 1, 36'h3},
    '{OP_LCMP, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 32'd0, 1, 36'h0},
    '{OP_LCMP, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 16'h8000, 32'hFFFF_FFFF, 1, 36'h1},
    '{OP_FCMPL, 64'h7FC0_0000, 64'h3F80_0000, 16'd0, 32'd0, 1, 36'h3},
    '{OP_FCMPG, 64'h3F80_0000, 64'h7FC0_0000, 16'd0, 32'd0, 1, 36'h1},
    '{OP_FCMPL, 64'h8000_0000, 64'h0, 16'd0, 32'd0, 1, 36'h0},
    '{OP_FCMPG, 64'hBF80_0000, 64'hFF80_0000, 16'd0, 32'd0, 0, 36'h0},
    '{OP_DCMPL, 64'h7FF0_0000_0000_0001, 64'h0, 16'd0, 32'd0, 1, 36'h3},
    '{OP_DCMPG, 64'hFFF8_0000_0000_0000, 64'h0, 16'd0, 32'd0, 1, 36'h1},
    '{OP_DCMPG, 64'h8000_0000_0000_0000, 64'h0, 16'd0, 32'd0, 1, 36'h0},
    '{OP_DCMPL, 64'h7FF0_0000_0000_0000, 64'hFFEF_FFFF_FFFF_FFFF, 16'd0, 32'd0, 0, 36'h0},
    '{OP_IFEQ, 64'hFFFF_FFFF_0000_0000, 64'h5, 16'h7FFF, 32'hFFFF_FFF0, 1, 36'h0_0007_FEFC},
    '{OP_IFNE, 64'h1, 64'h0, 16'h8000, 32'h0, 1, 36'hF_FFF8_000C},
    '{OP_IFLT, 64'h8000_0000, 64'h0, 16'd8, 32'd16, 0, 36'h0},
    '{OP_IFGE, 64'h8000_0000, 64'h0, 16'd8, 32'd16, 1, 36'h4},
    '{OP_IFGT, 64'h7FFF_FFFF, 64'h0, 16'hFFFF, 32'h0, 0, 36'h0},
    '{OP_IFLE, 64'h0, 64'h0, 16'd2, 32'd2, 0, 36'h0},
    '{OP_ICMPEQ, 64'h1_0000_0007, 64'h7, 16'd3, 32'd1, 0, 36'h0},
    '{OP_ICMPNE, 64'h7, 64'h7, 16'd3, 32'd1, 1, 36'h4},
    '{OP_ICMPLT, 64'h8000_0000, 64'h7FFF_FFFF, 16'd3, 32'd1, 0, 36'h0},
    '{OP_ICMPGE, 64'h8000_0000, 64'h7FFF_FFFF, 16'd3, 32'd1, 0, 36'h0},
    '{OP_ICMPGT, 64'hFFFF_FFFF, 64'hFFFF_FFFE, 16'd3, 32'd1, 0, 36'h0},
    '{OP_ICMPLE, 64'h5, 64'h5, 16'd3, 32'd1, 0, 36'h0},
    '{OP_ACMPEQ, 64'h1_0000_0000, 64'h0, 16'd3, 32'd1, 1, 36'h4},
    '{OP_ACMPNE, 64'h1_0000_0000, 64'h0, 16'd3, 32'd1, 0, 36'h0},
    '{5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 16'hFFFF, 32'hFFFF_FFFF, 1, 36'h0}
  };

  initial begin
    logic [4:0] op;
    logic [35:0] want;
    int phase;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      if (directed[i].known) begin
        want = branch_outcome(directed[i].op, directed[i].a, directed[i].b,
                              directed[i].off, directed[i].pc);
        if (want != directed[i].res) report_mismatch("table row", want, directed[i].res);
      end
      send_instruction(directed[i].op, directed[i].a, directed[i].b, directed[i].off,
                       directed[i].pc);
    end
    for (int n = 0; n < 650; n++) begin
      phase = n / 130;
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 75; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 75; end
        3: begin send_idle_pct = 15; recv_stall_pct = 15; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (n == 60) fork
        begin
          hold_off = 1'b1;
          repeat (60) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
      if (n == 300 && pending_results.size() != 0) begin
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      op = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 19)) : 5'($urandom_range(18));
      if ($urandom_range(3) == 0) begin
        logic [63:0] a;
        a = pick_operand(op == OP_DCMPL || op == OP_DCMPG);
        send_instruction(op, a, ($urandom_range(1) ? a : a ^ 64'h8000_0000_0000_0000),
                         16'($urandom), $urandom);
      end else begin
        send_instruction(op, pick_operand(op == OP_DCMPL || op == OP_DCMPG),
                         pick_operand(op == OP_DCMPL || op == OP_DCMPG), 16'($urandom), $urandom);
      end
    end
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS stack_vm_compare_and_branch_unit");
    end else begin
      $display("FAIL stack_vm_compare_and_branch_unit");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+design
design/svcb_pkg.sv
design/svcb_exec.sv
design/stack_vm_compare_and_branch_unit.sv
sim/tb_stack_vm_compare_and_branch_unit.sv
